// ----- src/assert_macros.svh -----
// Shared assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CWPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deframer assertion failed");

// Check that a condition in one cycle implies a condition in the next.
`define CWPD_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("deframer sequencing assertion failed");

`endif

// ----- src/cwpd_pkg.sv -----
package cwpd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int POS_W  = 3;
  localparam int CFG_IDX_W = 1;

  // Register reset values
  localparam logic [BYTE_W-1:0] CRC_POLY_RST = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT_RST = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT = 1'd1;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_W0_HI = 3'd0;
  localparam logic [POS_W-1:0] POS_W0_LO = 3'd1;
  localparam logic [POS_W-1:0] POS_W0_CRC = 3'd2;
  localparam logic [POS_W-1:0] POS_W1_HI = 3'd3;
  localparam logic [POS_W-1:0] POS_W1_LO = 3'd4;
  localparam logic [POS_W-1:0] POS_W1_CRC = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
    logic              first_crc_ok;
    logic              second_crc_ok;
    logic              frame_ok;
  } out_item_t;

  // Result handoff from the frame datapath to the output register
  typedef struct packed {
    logic      last;
    out_item_t item;
  } frame_res_t;

  // Feed one byte into an MSB-first CRC-8
  function automatic logic [BYTE_W-1:0] crc8_feed(
    input logic [BYTE_W-1:0] crc,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] poly
  );
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/cwpd_frame.sv -----
module cwpd_frame
  import cwpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  in_item_t             item,
  input  logic                 take,
  output frame_res_t           res
);

  logic [BYTE_W-1:0] crc_poly_r;
  logic [BYTE_W-1:0] crc_init_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] word0_r, word0_nxt;
  logic [WORD_W-1:0] word1_r, word1_nxt;
  logic              ok0_r, ok0_nxt;
  logic [POS_W-1:0]  pos_eff;
  logic [BYTE_W-1:0] crc_seed;
  logic [BYTE_W-1:0] crc_fed;
  logic              byte_match;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= CRC_POLY_RST;
      crc_init_r <= CRC_INIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CRC_POLY: crc_poly_r <= cfg_wdata;
        CFG_CRC_INIT: crc_init_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Restart on a start mark or an out-of-range position
  always_comb begin
    if (item.frame_start || (pos_r inside {[3'd6:3'd7]})) begin
      pos_eff = POS_W0_HI;
    end else begin
      pos_eff = pos_r;
    end
  end

  // Seed the CRC at the top byte of each word
  assign crc_seed = (pos_eff == POS_W0_HI || pos_eff == POS_W1_HI) ? crc_init_r : crc_r;
  assign crc_fed = crc8_feed(crc_seed, item.data_byte, crc_poly_r);
  assign byte_match = (item.data_byte == crc_r);

  // Advance the frame state for the byte in the stage
  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    word0_nxt = word0_r;
    word1_nxt = word1_r;
    ok0_nxt   = ok0_r;
    case (pos_eff)
      POS_W0_HI: begin
        crc_nxt   = crc_fed;
        word0_nxt = {item.data_byte, {BYTE_W{1'b0}}};
        pos_nxt   = POS_W0_LO;
      end
      POS_W0_LO: begin
        crc_nxt   = crc_fed;
        word0_nxt = {word0_r[WORD_W-1:BYTE_W], item.data_byte};
        pos_nxt   = POS_W0_CRC;
      end
      POS_W0_CRC: begin
        ok0_nxt = byte_match;
        crc_nxt = crc_init_r;
        pos_nxt = POS_W1_HI;
      end
      POS_W1_HI: begin
        crc_nxt   = crc_fed;
        word1_nxt = {item.data_byte, {BYTE_W{1'b0}}};
        pos_nxt   = POS_W1_LO;
      end
      POS_W1_LO: begin
        crc_nxt   = crc_fed;
        word1_nxt = {word1_r[WORD_W-1:BYTE_W], item.data_byte};
        pos_nxt   = POS_W1_CRC;
      end
      default: begin
        crc_nxt = crc_init_r;
        pos_nxt = POS_W0_HI;
      end
    endcase
  end

  // Build the result for the closing CRC byte
  always_comb begin
    res.last               = (pos_eff == POS_W1_CRC);
    res.item.first_word    = word0_r;
    res.item.second_word   = word1_r;
    res.item.first_crc_ok  = ok0_r;
    res.item.second_crc_ok = byte_match;
    res.item.frame_ok      = ok0_r & byte_match;
  end

  // Commit state when the stage byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_W0_HI;
      crc_r   <= CRC_INIT_RST;
      word0_r <= '0;
      word1_r <= '0;
      ok0_r   <= 1'b0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      word0_r <= word0_nxt;
      word1_r <= word1_nxt;
      ok0_r   <= ok0_nxt;
    end
  end

`include "assert_macros.svh"

  `CWPD_ASSERT(a_pos_range, clk, rst_n, pos_r <= POS_W1_CRC)
  `CWPD_ASSERT_NEXT(a_start_pos, clk, rst_n, take && item.frame_start, pos_r == POS_W0_LO)
  `CWPD_ASSERT_NEXT(a_last_wrap, clk, rst_n, take && res.last, pos_r == POS_W0_HI && crc_r == crc_init_r)

endmodule

// ----- src/cwpd_out_reg.sv -----
module cwpd_out_reg
  import cwpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // Free when empty or when the held result leaves this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

`include "assert_macros.svh"

  `CWPD_ASSERT(a_no_overwrite, clk, rst_n, load |-> free)

endmodule

// ----- src/crc_checked_word_pair_deframer.sv -----
// Channel  | Ports                               | Moves
// -------- | ----------------------------------- | ------------------------------
// input    | in_valid, in_ready, in_item         | one received byte per transfer
// result   | out_valid, out_ready, out_item      | two words and CRC flags
// config   | cfg_we, cfg_idx, cfg_wdata          | polynomial (0), initial (1)
//
// Takes one byte per cycle unless a closing byte waits on a full result
// register; a result is valid once the closing CRC byte has passed the input
// register and the frame datapath has loaded the result register. The
// combinational CRC-8 XOR network sets the stage delay.
// Reset is synchronous, active low; it restores default polynomial and init.
// Only a closing byte waits on a full result register; input stalls meanwhile.
module crc_checked_word_pair_deframer
  import cwpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  logic       s1_valid_r, s1_valid_nxt;
  in_item_t   s1_item_r;
  frame_res_t res;
  logic       out_free;
  logic       s1_go;
  logic       in_take;

  // Advance the stage unless a result would hit a full output register
  assign s1_go    = s1_valid_r && (!res.last || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  cwpd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .item      (s1_item_r),
    .take      (s1_go),
    .res       (res)
  );

  cwpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go && res.last),
    .load_item (res.item),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`include "assert_macros.svh"

  `CWPD_ASSERT(a_stall_last, clk, rst_n, s1_valid_r && res.last && !out_free |-> !in_ready)
  `CWPD_ASSERT_NEXT(a_result_lands, clk, rst_n, s1_go && res.last, out_valid)

endmodule
